>>> src/perc_pkg.sv
// ----------------------------------------------------------------------------
// Printer escape raster capture package
// Shared types, character codes and event codes for the capture unit.
// ----------------------------------------------------------------------------
package perc_pkg;

    // Default image buffer size in bytes
    localparam int unsigned IMAGE_BYTES_DEF = 65536;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_FIELD_W = 82;
    localparam int unsigned OUT_TDATA_W = 88;

    // Character codes
    localparam logic [7:0] CH_ESC       = 8'd27;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_INTER_LO  = 8'd33;
    localparam logic [7:0] CH_INTER_HI  = 8'd47;
    localparam logic [7:0] CH_DIGIT_LO  = 8'd48;
    localparam logic [7:0] CH_DIGIT_HI  = 8'd57;
    localparam logic [7:0] CH_UPPER_LO  = 8'd64;
    localparam logic [7:0] CH_UPPER_HI  = 8'd94;
    localparam logic [7:0] CH_LOWER_LO  = 8'd96;
    localparam logic [7:0] CH_LOWER_HI  = 8'd126;
    localparam logic [7:0] CH_PLUS      = 8'd43;
    localparam logic [7:0] CH_MINUS     = 8'd45;
    localparam logic [7:0] CH_STAR      = 8'd42;
    localparam logic [7:0] CH_B_LOWER   = 8'd98;
    localparam logic [7:0] CH_R_LOWER   = 8'd114;
    localparam logic [7:0] CH_W_UPPER   = 8'd87;
    localparam logic [7:0] CH_A_UPPER   = 8'd65;
    localparam logic [7:0] CH_B_UPPER   = 8'd66;
    localparam logic [7:0] CH_C_UPPER   = 8'd67;

    localparam logic [15:0] ARG_MAX  = 16'hFFFF;
    localparam logic [15:0] ROWS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_ESC   = 2'd1,
        PH_INTER = 2'd2,
        PH_ARG   = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_PRINTABLE = 4'd1,
        EV_NONPRINT  = 4'd2,
        EV_TWOCHAR   = 4'd3,
        EV_LOWER     = 4'd4,
        EV_ROW_START = 4'd5,
        EV_GFX_START = 4'd6,
        EV_GFX_END   = 4'd7,
        EV_OTHER     = 4'd8,
        EV_RASTER    = 4'd9
    } t_event;

endpackage

>>> src/printer_escape_raster_capture_unit.sv
// ----------------------------------------------------------------------------
// Printer escape raster capture unit
// Parses a printer command byte stream and reports one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_axis_*) carries one command-stream byte per transfer.
//   Master channel (o_m_axis_*) carries exactly one result per input byte,
//   in input order. Each result reports the event for that byte (text,
//   escape-sequence decode, raster row start, graphics start/end, raster
//   data byte), the echoed byte, the image write address with its wrap
//   flag, the parsed argument, and the current row width, row count and
//   graphics flag.
// Path: each byte passes the input register, then the result register,
//   before its result shows valid on the master channel.
// Throughput: one byte per cycle while the receiver keeps tready high. All
//   decode work for a byte is a few compares, a times-ten add and counter
//   updates between the input register and the result register.
// Stall: when the receiver holds tready low, the result register holds; the
//   input register still takes one more byte if empty, then tready drops.
// Reset: synchronous, active low; parser returns to text phase, all
//   counters, width, argument and graphics flag clear, both stages empty.
// ----------------------------------------------------------------------------
module printer_escape_raster_capture_unit #(
    parameter int unsigned IMAGE_BYTES = perc_pkg::IMAGE_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] in_byte
    input  logic [perc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [3:0] event_res, [11:4] data_byte, [27:12] write_address,
    // [28] buffer_wrapped, [44:29] argument, [63:45] row_width_bits,
    // [79:64] row_count, [80] width_changed, [81] graphics_active,
    // [87:82] zero
    output logic [perc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import perc_pkg::*;

    // Offset counter must be able to hold IMAGE_BYTES itself
    localparam int unsigned OFS_W = $clog2(IMAGE_BYTES + 1);
    localparam logic [OFS_W-1:0] OFS_LIMIT = OFS_W'(IMAGE_BYTES);

    // ---------------- pipeline control ----------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       w_advance;
    logic       w_fire;

    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_advance;
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign o_m_axis_tvalid = r_out_valid;

    // ---------------- parser state ----------------
    t_phase           r_phase, n_phase;
    logic [7:0]       r_inter, n_inter;
    logic [7:0]       r_group, n_group;
    logic [15:0]      r_arg, n_arg;
    logic             r_arg_started, n_arg_started;
    logic [15:0]      r_raster_left, n_raster_left;
    logic [OFS_W-1:0] r_offset, n_offset;
    logic [18:0]      r_width, n_width;
    logic [15:0]      r_rows, n_rows;
    logic             r_gfx, n_gfx;

    // ---------------- per-byte results ----------------
    t_event      n_ev;
    logic [15:0] n_addr;
    logic        n_wrap;
    logic [15:0] n_arg_out;
    logic        n_wchg;

    logic [OUT_FIELD_W-1:0] r_out_fields;

    // Helpers for the decode
    logic        w_sign;
    logic        w_digit;
    logic [19:0] w_arg_next;
    logic [3:0]  w_digit_val;
    logic [18:0] w_new_width;
    logic [OFS_W-1:0] w_wr_ofs;
    logic [31:0] w_ofs_ext;
    logic [15:0] w_rows_base;

    always_comb begin
        logic [7:0] c;
        c = r_in_byte;

        // hold by default
        n_phase       = r_phase;
        n_inter       = r_inter;
        n_group       = r_group;
        n_arg         = r_arg;
        n_arg_started = r_arg_started;
        n_raster_left = r_raster_left;
        n_offset      = r_offset;
        n_width       = r_width;
        n_rows        = r_rows;
        n_gfx         = r_gfx;

        n_ev      = EV_NONE;
        n_addr    = '0;
        n_wrap    = 1'b0;
        n_arg_out = '0;
        n_wchg    = 1'b0;

        w_sign      = (c == CH_PLUS) || (c == CH_MINUS);
        w_digit     = (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
        w_digit_val = w_sign ? 4'd0 : 4'(c - CH_DIGIT_LO);
        // arg * 10 + digit, then saturate
        w_arg_next  = {1'b0, r_arg, 3'b000} + {3'b000, r_arg, 1'b0}
                    + {16'd0, w_digit_val};
        w_new_width = {r_arg, 3'b000};
        w_wr_ofs    = (r_offset >= OFS_LIMIT) ? '0 : r_offset;
        w_ofs_ext   = 32'(w_wr_ofs);
        w_rows_base = (r_width != w_new_width) ? 16'd0 : r_rows;

        if (r_raster_left != 16'd0) begin
            // raster data wins over any parse phase
            n_wrap        = (r_offset >= OFS_LIMIT);
            n_addr        = w_ofs_ext[15:0];
            n_offset      = w_wr_ofs + OFS_W'(1);
            n_raster_left = r_raster_left - 16'd1;
            n_ev          = EV_RASTER;
        end else begin
            case (r_phase)
                PH_TEXT: begin
                    if (c == CH_ESC) begin
                        n_phase = PH_ESC;
                    end else if (c >= CH_SPACE && c <= CH_LOWER_HI) begin
                        n_ev = EV_PRINTABLE;
                    end else begin
                        n_ev = EV_NONPRINT;
                    end
                end
                PH_ESC: begin
                    if (c >= CH_INTER_LO && c <= CH_INTER_HI) begin
                        n_inter = c;
                        n_phase = PH_INTER;
                    end else if (c >= CH_DIGIT_LO && c <= CH_LOWER_HI) begin
                        n_phase = PH_TEXT;
                        n_ev    = EV_TWOCHAR;
                    end
                end
                PH_INTER: begin
                    if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) begin
                        n_group       = c;
                        n_arg         = '0;
                        n_arg_started = 1'b0;
                        n_phase       = PH_ARG;
                    end else begin
                        n_phase = PH_TEXT;
                    end
                end
                PH_ARG: begin
                    if (w_sign || w_digit) begin
                        // a leading sign is skipped
                        if (!(w_sign && !r_arg_started)) begin
                            n_arg = (w_arg_next > 20'(ARG_MAX)) ? ARG_MAX
                                                                : w_arg_next[15:0];
                        end
                        n_arg_started = 1'b1;
                    end else if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) begin
                        n_arg_out     = r_arg;
                        n_arg         = '0;
                        n_arg_started = 1'b0;
                        n_ev          = EV_LOWER;
                    end else if (c >= CH_UPPER_LO && c <= CH_UPPER_HI) begin
                        n_arg_out = r_arg;
                        n_phase   = PH_TEXT;
                        n_ev      = EV_OTHER;
                        if (r_inter == CH_STAR) begin
                            if (r_group == CH_B_LOWER && c == CH_W_UPPER) begin
                                if (r_width != w_new_width) begin
                                    n_wchg   = 1'b1;
                                    n_width  = w_new_width;
                                    n_offset = '0;
                                end
                                n_rows = (w_rows_base != ROWS_MAX) ?
                                         w_rows_base + 16'd1 : w_rows_base;
                                n_raster_left = r_arg;
                                n_ev          = EV_ROW_START;
                            end else if (r_group == CH_R_LOWER) begin
                                if (c == CH_A_UPPER) begin
                                    n_gfx    = 1'b1;
                                    n_width  = '0;
                                    n_rows   = '0;
                                    n_offset = '0;
                                    n_ev     = EV_GFX_START;
                                end else if (c == CH_B_UPPER || c == CH_C_UPPER) begin
                                    n_gfx = 1'b0;
                                    n_ev  = EV_GFX_END;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_TEXT;
                end
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // ---------------- state update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TEXT;
            r_inter       <= '0;
            r_group       <= '0;
            r_arg         <= '0;
            r_arg_started <= 1'b0;
            r_raster_left <= '0;
            r_offset      <= '0;
            r_width       <= '0;
            r_rows        <= '0;
            r_gfx         <= 1'b0;
        end else if (w_fire) begin
            r_phase       <= n_phase;
            r_inter       <= n_inter;
            r_group       <= n_group;
            r_arg         <= n_arg;
            r_arg_started <= n_arg_started;
            r_raster_left <= n_raster_left;
            r_offset      <= n_offset;
            r_width       <= n_width;
            r_rows        <= n_rows;
            r_gfx         <= n_gfx;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_out_fields <= {n_gfx, n_wchg, n_rows, n_width, n_arg_out,
                             n_wrap, n_addr, r_in_byte, n_ev};
        end
    end

    assign o_m_axis_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), r_out_fields};

    // ---------------- assertions ----------------
    // Offset never runs past the buffer size
    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= OFS_LIMIT)
        else $error("image offset beyond buffer size");

    // Width is always a whole number of bytes
    a_width_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_width[2:0] == 3'd0)
        else $error("row width not a multiple of eight");

    // Address and wrap flag only accompany raster bytes
    a_addr_raster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fields[3:0] != EV_RASTER) |->
        (r_out_fields[28:12] == 17'd0))
        else $error("write address on a non-raster result");

    // A width change is only reported on a row start
    a_wchg_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fields[80]) |-> (r_out_fields[3:0] == EV_ROW_START))
        else $error("width change outside a row start");

    // A row start with data leaves raster bytes pending
    a_row_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_ev == EV_ROW_START && r_arg != 16'd0) |=>
        (r_raster_left != 16'd0))
        else $error("row start did not arm raster count");

endmodule

>>> verif/printer_escape_raster_capture_unit_test.sv
// ----------------------------------------------------------------------------
// Printer escape raster capture unit testbench
// Feeds command-stream bytes through the slave stream port and compares each
// result transfer field by field against a cycle-free predictor of the parser.
// Covers text classes, escape sequences, argument signs and saturation, raster
// rows and graphics start/end, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module printer_escape_raster_capture_unit_test;

    import perc_pkg::*;

    localparam int unsigned IMAGE_SIZE = IMAGE_BYTES_DEF;

    // One result transfer, laid out as the tdata bus (lowest field last here)
    typedef struct packed {
        logic [5:0]  pad;
        logic        gfx;
        logic        wchg;
        logic [15:0] rows;
        logic [18:0] width_bits;
        logic [15:0] arg;
        logic        wrap;
        logic [15:0] addr;
        logic [7:0]  data;
        t_event      ev;
    } t_capture_result;

    // ------------------------------------------------------------------------
    // Parser predictor and result checker
    // ------------------------------------------------------------------------
    class capture_scoreboard;
        t_phase      phase      = PH_TEXT;
        logic [7:0]  inter_ch   = '0;
        logic [7:0]  group_ch   = '0;
        logic [15:0] arg_acc    = '0;
        logic        arg_begun  = 1'b0;
        logic [15:0] raster_cnt = '0;
        logic [16:0] img_off    = '0;
        logic [19:0] width_px   = '0;
        logic [15:0] row_cnt    = '0;
        logic        gfx_on     = 1'b0;

        t_capture_result expected_results[$];
        int unsigned fail_count = 0;
        int unsigned n_checked  = 0;
        int unsigned n_bytes    = 0;
        int unsigned n_raster   = 0;
        int unsigned n_wrapped  = 0;
        int unsigned n_rows     = 0;
        int unsigned n_gfx      = 0;

        // Advance the parser by one accepted byte and queue its result
        function void predict_byte(logic [7:0] c);
            t_capture_result r;
            logic            is_sign;
            logic [3:0]      digit;
            logic [19:0]     acc_next;
            logic [18:0]     new_width;
            r = '0;
            r.ev = EV_NONE;
            r.data = c;
            if (raster_cnt != 0) begin
                // raster bytes win over any parser phase
                if (img_off >= IMAGE_SIZE) begin
                    img_off = '0;
                    r.wrap = 1'b1;
                end
                r.addr = img_off[15:0];
                img_off++;
                raster_cnt--;
                r.ev = EV_RASTER;
            end else begin
                case (phase)
                    PH_TEXT: begin
                        if (c == CH_ESC)
                            phase = PH_ESC;
                        else if (c >= CH_SPACE && c <= CH_LOWER_HI)
                            r.ev = EV_PRINTABLE;
                        else
                            r.ev = EV_NONPRINT;
                    end
                    PH_ESC: begin
                        if (c >= CH_INTER_LO && c <= CH_INTER_HI) begin
                            inter_ch = c;
                            phase = PH_INTER;
                        end else if (c >= CH_DIGIT_LO && c <= CH_LOWER_HI) begin
                            phase = PH_TEXT;
                            r.ev = EV_TWOCHAR;
                        end
                    end
                    PH_INTER: begin
                        if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) begin
                            group_ch = c;
                            arg_acc = '0;
                            arg_begun = 1'b0;
                            phase = PH_ARG;
                        end else begin
                            phase = PH_TEXT;
                        end
                    end
                    default: begin
                        is_sign = (c == CH_PLUS || c == CH_MINUS);
                        if (is_sign || (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI)) begin
                            // a leading sign is skipped, a later one is a zero digit
                            if (!(is_sign && !arg_begun)) begin
                                digit = is_sign ? 4'd0 : 4'(c - CH_DIGIT_LO);
                                acc_next = arg_acc * 20'd10 + digit;
                                arg_acc = (acc_next > 20'(ARG_MAX)) ? ARG_MAX
                                                                     : acc_next[15:0];
                            end
                            arg_begun = 1'b1;
                        end else if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) begin
                            r.arg = arg_acc;
                            arg_acc = '0;
                            arg_begun = 1'b0;
                            r.ev = EV_LOWER;
                        end else if (c >= CH_UPPER_LO && c <= CH_UPPER_HI) begin
                            r.arg = arg_acc;
                            phase = PH_TEXT;
                            r.ev = EV_OTHER;
                            if (inter_ch == CH_STAR && group_ch == CH_B_LOWER
                                    && c == CH_W_UPPER) begin
                                new_width = {arg_acc, 3'b000};
                                if (width_px != {1'b0, new_width}) begin
                                    r.wchg = 1'b1;
                                    width_px = {1'b0, new_width};
                                    row_cnt = '0;
                                    img_off = '0;
                                end
                                if (row_cnt != ROWS_MAX)
                                    row_cnt++;
                                raster_cnt = arg_acc;
                                r.ev = EV_ROW_START;
                            end else if (inter_ch == CH_STAR && group_ch == CH_R_LOWER) begin
                                if (c == CH_A_UPPER) begin
                                    gfx_on = 1'b1;
                                    width_px = '0;
                                    row_cnt = '0;
                                    img_off = '0;
                                    r.ev = EV_GFX_START;
                                end else if (c == CH_B_UPPER || c == CH_C_UPPER) begin
                                    gfx_on = 1'b0;
                                    r.ev = EV_GFX_END;
                                end
                            end
                        end
                    end
                endcase
            end
            r.width_bits = width_px[18:0];
            r.rows = row_cnt;
            r.gfx = gfx_on;
            n_bytes++;
            if (r.ev == EV_RASTER) n_raster++;
            if (r.wrap) n_wrapped++;
            if (r.ev == EV_ROW_START) n_rows++;
            if (r.ev == EV_GFX_START || r.ev == EV_GFX_END) n_gfx++;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            fail_count++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                          n_checked, name, got, want));
        endtask

        // Check one result transfer against the oldest expectation
        task check_result(logic [OUT_TDATA_W-1:0] tdata);
            t_capture_result got;
            t_capture_result want;
            got = t_capture_result'(tdata);
            n_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no byte outstanding",
                                          n_checked));
                return;
            end
            want = expected_results.pop_front();
            compare_field("event_res", 32'(got.ev), 32'(want.ev));
            compare_field("data_byte", 32'(got.data), 32'(want.data));
            compare_field("write_address", 32'(got.addr), 32'(want.addr));
            compare_field("buffer_wrapped", 32'(got.wrap), 32'(want.wrap));
            compare_field("argument", 32'(got.arg), 32'(want.arg));
            compare_field("row_width_bits", 32'(got.width_bits), 32'(want.width_bits));
            compare_field("row_count", 32'(got.rows), 32'(want.rows));
            compare_field("width_changed", 32'(got.wchg), 32'(want.wchg));
            compare_field("graphics_active", 32'(got.gfx), 32'(want.gfx));
            compare_field("padding", 32'(got.pad), 32'(want.pad));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    capture_scoreboard sb = new();

    logic [7:0] cmd_bytes[$];
    int unsigned last_row_n = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    printer_escape_raster_capture_unit #(
        .IMAGE_BYTES(IMAGE_SIZE)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Sink: stall on a rotating ready pattern, reloaded now and then; some
    // patterns are all ones so long stretches run without backpressure.
    // ------------------------------------------------------------------------
    logic [7:0]  ready_pattern = 8'hFF;
    int unsigned pattern_age   = 0;

    always @(posedge clk) begin
        if (pattern_age == 0) begin
            if ($urandom_range(0, 3) == 0)
                ready_pattern = 8'hFF;
            else
                ready_pattern = 8'($urandom) | 8'h11;
        end
        pattern_age = (pattern_age + 1) % 200;
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
        m_tready <= ready_pattern[0];
    end

    // Check every result transfer; sampled values are those before this edge
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Drive one byte and hold it until the transfer completes
    task automatic send_byte(logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.predict_byte(b);
    endtask

    // Drain the command queue in bursts with random gaps between them
    task automatic play_stream();
        int unsigned burst;
        int unsigned gap;
        while (cmd_bytes.size() != 0) begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && cmd_bytes.size() != 0) begin
                send_byte(cmd_bytes.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic push_str(string s);
        for (int k = 0; k < s.len(); k++)
            cmd_bytes.push_back(s[k]);
    endtask

    task automatic push_raster(int unsigned n);
        repeat (n) cmd_bytes.push_back(8'($urandom));
    endtask

    // Decimal argument with an optional leading sign, a sign in the middle
    // (counts as a zero digit) or no digits at all
    function automatic string arg_text(int unsigned value);
        string s;
        s = $sformatf("%0d", value);
        case ($urandom_range(0, 6))
            0: s = {"+", s};
            1: s = {"-", s};
            2: s = {s.substr(0, 0), "-", s.substr(1, s.len() - 1)};
            3: s = "";
            default: ;
        endcase
        return s;
    endfunction

    // Any byte that the argument phase ignores
    function automatic logic [7:0] ignored_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == CH_PLUS || b == CH_MINUS || (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI)
               || (b >= CH_UPPER_LO && b <= CH_UPPER_HI)
               || (b >= CH_LOWER_LO && b <= CH_LOWER_HI));
        return b;
    endfunction

    task automatic load_directed();
        // text extremes and the printable boundaries
        cmd_bytes = {8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h1F};
        // byte outside 33..126 after ESC is dropped, then a two-char discard
        cmd_bytes.push_back(CH_ESC);
        push_str(" Z");
        // bad group char falls back to text silently
        cmd_bytes.push_back(CH_ESC);
        push_str("!A");
        cmd_bytes.push_back(CH_ESC);
        push_str("*rA");
        // leading plus, and an ESC inside raster data
        cmd_bytes.push_back(CH_ESC);
        push_str("*b+2W");
        cmd_bytes.push_back(CH_ESC);
        cmd_bytes.push_back(8'h00);
        // leading minus skipped, later minus is a zero digit: 10 bytes
        cmd_bytes.push_back(CH_ESC);
        push_str("*b-1-W");
        push_raster(10);
        // ignored byte in the argument, lowercase report, zero-length row
        cmd_bytes.push_back(CH_ESC);
        push_str("*b1:2m0W");
        cmd_bytes.push_back(CH_ESC);
        push_str("*rB");
        cmd_bytes.push_back(CH_ESC);
        push_str("*rC");
        cmd_bytes.push_back(CH_ESC);
        push_str("&l3X");
        cmd_bytes.push_back(CH_ESC);
        push_str("*r1Q");
        // saturated argument on a discard and on a lowercase report, then a
        // zero-length row of unchanged width
        cmd_bytes.push_back(CH_ESC);
        push_str("*r99999Q");
        cmd_bytes.push_back(CH_ESC);
        push_str("*b70000x0W");
        // two rows of the same width keep counting rows
        cmd_bytes.push_back(CH_ESC);
        push_str("*b3W");
        push_raster(3);
        cmd_bytes.push_back(CH_ESC);
        push_str("*b3W");
        push_raster(3);
        cmd_bytes.push_back(CH_ESC);
        push_str("*rA");
    endtask

    // Mostly well-formed commands with random content, plus noise
    task automatic load_random(int unsigned target);
        int unsigned n;
        logic [7:0]  grp;
        logic [7:0]  act;
        while (cmd_bytes.size() < target) begin
            case ($urandom_range(0, 11))
                0, 1: repeat ($urandom_range(1, 6)) cmd_bytes.push_back(8'($urandom));
                2, 3, 4: begin
                    n = ($urandom_range(0, 3) == 0) ? last_row_n : $urandom_range(0, 12);
                    last_row_n = n;
                    cmd_bytes.push_back(CH_ESC);
                    push_str({"*b", arg_text(n), "W"});
                    push_raster(n);
                end
                5: begin
                    cmd_bytes.push_back(CH_ESC);
                    push_str({"*r", arg_text($urandom_range(0, 9)), "A"});
                end
                6: begin
                    cmd_bytes.push_back(CH_ESC);
                    push_str("*r");
                    cmd_bytes.push_back($urandom_range(0, 1) ? CH_B_UPPER : CH_C_UPPER);
                end
                7: begin
                    // lowercase action in the middle of a sequence
                    grp = $urandom_range(0, 1) ? CH_B_LOWER : CH_R_LOWER;
                    cmd_bytes.push_back(CH_ESC);
                    cmd_bytes.push_back(CH_STAR);
                    cmd_bytes.push_back(grp);
                    push_str(arg_text($urandom_range(0, 99)));
                    cmd_bytes.push_back(8'($urandom_range(96, 126)));
                    n = $urandom_range(0, 12);
                    push_str(arg_text(n));
                    if (grp == CH_B_LOWER) begin
                        cmd_bytes.push_back(CH_W_UPPER);
                        push_raster(n);
                    end else begin
                        act = CH_A_UPPER + 8'($urandom_range(0, 2));
                        cmd_bytes.push_back(act);
                    end
                end
                8: begin
                    // arbitrary command; large arguments only off the '*' set
                    act = 8'($urandom_range(33, 47));
                    cmd_bytes.push_back(CH_ESC);
                    cmd_bytes.push_back(act);
                    cmd_bytes.push_back(8'($urandom_range(96, 126)));
                    if (act == CH_STAR)
                        push_str(arg_text($urandom_range(0, 12)));
                    else
                        push_str(arg_text($urandom_range(0, 3) == 0 ? 99999
                                                                    : $urandom_range(0, 999)));
                    if ($urandom_range(0, 3) == 0)
                        cmd_bytes.push_back(ignored_byte());
                    cmd_bytes.push_back(8'($urandom_range(64, 94)));
                end
                9: begin
                    cmd_bytes.push_back(CH_ESC);
                    if ($urandom_range(0, 1))
                        cmd_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 32))
                                                                 : 8'($urandom_range(127, 255)));
                    cmd_bytes.push_back(8'($urandom_range(48, 126)));
                end
                10: begin
                    cmd_bytes.push_back(CH_ESC);
                    cmd_bytes.push_back(8'($urandom_range(33, 47)));
                    cmd_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 95))
                                                             : 8'($urandom_range(127, 255)));
                end
                default: begin
                    cmd_bytes.push_back(CH_ESC);
                    repeat ($urandom_range(1, 4)) cmd_bytes.push_back(8'($urandom));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_directed();
        play_stream();
        load_random(800);
        play_stream();

        // wait for the pipeline to empty, then a few cycles for strays
        waited = 0;
        while (sb.expected_results.size() != 0 && waited < 2000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.expected_results.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.expected_results.size()));

        $display("Ran %0d command bytes: %0d raster writes (%0d wrapped), %0d row starts,",
                 sb.n_bytes, sb.n_raster, sb.n_wrapped, sb.n_rows);
        $display("%0d graphics start/end commands, %0d mismatches.",
                 sb.n_gfx, sb.fail_count);
        if (sb.fail_count == 0)
            $display("printer_escape_raster_capture_unit_test OK");
        else
            $display("printer_escape_raster_capture_unit_test NOT OK");
        $finish;
    end

    // Hard limit on the run length
    initial begin
        #50_000_000;
        $display("Timeout: stimulus or results stuck");
        $display("printer_escape_raster_capture_unit_test NOT OK");
        $finish;
    end

endmodule
